// ===== src/cclv_pkg.sv =====
package cclv_pkg;

  // Default line buffer size; the buffer holds one byte less than this.
  localparam int unsigned LineBytes = 32;

  localparam logic [7:0] CharTerm  = 8'h21;  // '!'
  localparam logic [7:0] CharBs    = 8'h08;
  localparam logic [7:0] CharDel   = 8'h7F;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowM  = 8'h6D;
  localparam logic [7:0] CharUpM   = 8'h4D;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [1:0] KindData     = 2'd0;
  localparam logic [1:0] KindInvalid  = 2'd1;
  localparam logic [1:0] KindOverflow = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push;       // store the incoming byte, bump fill
    logic       pop;        // drop the newest byte
    logic       clear_fill; // empty the line
    logic       clr_ptr;    // rewind the read pointer
    logic       ptr_inc;    // advance the read pointer
    logic       rd_en;      // read the line buffer at the pointer
    logic       chk_init;   // restart the syntax checker
    logic       chk_step;   // feed the read byte to the checker
    logic       load_data;  // load the read byte into the output word
    logic       load_err;   // load an error word
    logic [1:0] err_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_term;
    logic is_crlf;
    logic is_erase;
    logic fill_zero;
    logic fill_full;
    logic last_byte;
    logic out_free;
    logic parse_ok;
  } sts_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_m(input logic [7:0] c);
    return (c == CharLowM) || (c == CharUpM);
  endfunction

endpackage

// ===== src/cclv_datapath.sv =====
module cclv_datapath #(
  parameter int unsigned LINE_BYTES = cclv_pkg::LineBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  logic                out_ready_i,
  input  cclv_pkg::cmd_t      cmd_i,
  output cclv_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  output logic [1:0]          out_kind_o,
  output logic [7:0]          out_data_o,
  output logic                out_last_o
);

  localparam int unsigned Cap = LINE_BYTES - 1;
  localparam int unsigned FW  = $clog2(LINE_BYTES);
  localparam int unsigned AW  = $clog2(Cap);
  localparam logic [FW-1:0] CapVal = FW'(Cap);

  localparam logic [3:0] P_LEAD = 4'd0;
  localparam logic [3:0] P_SIGN = 4'd1;
  localparam logic [3:0] P_DIG  = 4'd2;
  localparam logic [3:0] P_GAP1 = 4'd3;
  localparam logic [3:0] P_M1   = 4'd4;
  localparam logic [3:0] P_M2   = 4'd5;
  localparam logic [3:0] P_GAP2 = 4'd6;
  localparam logic [3:0] P_BIT  = 4'd7;
  localparam logic [3:0] P_TAIL = 4'd8;
  localparam logic [3:0] P_FAIL = 4'd9;

  logic [7:0]    mem [Cap];
  logic [7:0]    rd_data_q;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [3:0]    pst_q, pst_d, pst_nxt;
  logic          ended_q, ended_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_data_q;
  logic          out_last_q;
  logic          out_free;
  logic          last_byte;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_byte = (FW'(ptr_q) == (fill_q - FW'(1)));

  always_comb begin
    sts_o.is_term   = (rx_byte_i == cclv_pkg::CharTerm);
    sts_o.is_crlf   = (rx_byte_i == cclv_pkg::CharCr) || (rx_byte_i == cclv_pkg::CharLf);
    sts_o.is_erase  = (rx_byte_i == cclv_pkg::CharBs) || (rx_byte_i == cclv_pkg::CharDel);
    sts_o.fill_zero = (fill_q == '0);
    sts_o.fill_full = (fill_q == CapVal);
    sts_o.last_byte = last_byte;
    sts_o.out_free  = out_free;
    sts_o.parse_ok  = (pst_q == P_BIT) || (pst_q == P_TAIL);
  end

  // Line buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[fill_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear_fill) begin
      fill_d = '0;
    end else if (cmd_i.push) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.pop) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.clr_ptr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  // Syntax check, one byte per step.
  always_comb begin
    pst_nxt = P_FAIL;
    case (pst_q)
      P_LEAD: begin
        if (cclv_pkg::is_blank(rd_data_q)) pst_nxt = P_LEAD;
        else if ((rd_data_q == cclv_pkg::CharPlus) || (rd_data_q == cclv_pkg::CharMinus))
          pst_nxt = P_SIGN;
        else if (cclv_pkg::is_digit(rd_data_q)) pst_nxt = P_DIG;
      end
      P_SIGN: begin
        if (cclv_pkg::is_digit(rd_data_q)) pst_nxt = P_DIG;
      end
      P_DIG: begin
        if (cclv_pkg::is_digit(rd_data_q)) pst_nxt = P_DIG;
        else if (cclv_pkg::is_blank(rd_data_q)) pst_nxt = P_GAP1;
        else if (cclv_pkg::is_m(rd_data_q)) pst_nxt = P_M1;
      end
      P_GAP1: begin
        if (cclv_pkg::is_blank(rd_data_q)) pst_nxt = P_GAP1;
        else if (cclv_pkg::is_m(rd_data_q)) pst_nxt = P_M1;
      end
      P_M1: begin
        if (cclv_pkg::is_m(rd_data_q)) pst_nxt = P_M2;
      end
      P_M2, P_GAP2: begin
        if (cclv_pkg::is_blank(rd_data_q)) pst_nxt = P_GAP2;
        else if ((rd_data_q == cclv_pkg::CharZero) || (rd_data_q == cclv_pkg::CharOne))
          pst_nxt = P_BIT;
      end
      P_BIT, P_TAIL: begin
        if (cclv_pkg::is_blank(rd_data_q)) pst_nxt = P_TAIL;
      end
      default: pst_nxt = P_FAIL;
    endcase
  end

  always_comb begin
    pst_d   = pst_q;
    ended_d = ended_q;
    if (cmd_i.chk_init) begin
      pst_d   = P_LEAD;
      ended_d = 1'b0;
    end else if (cmd_i.chk_step && !ended_q) begin
      // a zero byte ends the checked part of the line
      if (rd_data_q == cclv_pkg::CharNul) begin
        ended_d = 1'b1;
      end else begin
        pst_d = pst_nxt;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_data || cmd_i.load_err) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ptr_q       <= '0;
      pst_q       <= P_LEAD;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      pst_q       <= pst_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_data) begin
      out_kind_q <= cclv_pkg::KindData;
      out_data_q <= rd_data_q;
      out_last_q <= last_byte;
    end else if (cmd_i.load_err) begin
      out_kind_q <= cmd_i.err_kind;
      out_data_q <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== src/cclv_ctrl.sv =====
module cclv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cclv_pkg::sts_t sts_i,
  output cclv_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHK_RD  = 3'd1;
  localparam logic [2:0] ST_CHK_EV  = 3'd2;
  localparam logic [2:0] ST_CHK_END = 3'd3;
  localparam logic [2:0] ST_SND_RD  = 3'd4;
  localparam logic [2:0] ST_SND_LD  = 3'd5;
  localparam logic [2:0] ST_ERR     = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ovf_q, ovf_d;
  logic       take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    cmd_o   = '0;
    cmd_o.err_kind = ovf_q ? cclv_pkg::KindOverflow : cclv_pkg::KindInvalid;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (sts_i.is_term) begin
            if (!sts_i.fill_zero) begin
              cmd_o.chk_init = 1'b1;
              cmd_o.clr_ptr  = 1'b1;
              state_d        = ST_CHK_RD;
            end
          end else if (sts_i.is_crlf) begin
            // drop
          end else if (sts_i.is_erase) begin
            cmd_o.pop = !sts_i.fill_zero;
          end else if (!sts_i.fill_full) begin
            cmd_o.push = 1'b1;
          end else begin
            cmd_o.clear_fill = 1'b1;
            ovf_d            = 1'b1;
            state_d          = ST_ERR;
          end
        end
      end
      ST_CHK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHK_EV;
      end
      ST_CHK_EV: begin
        cmd_o.chk_step = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = sts_i.last_byte ? ST_CHK_END : ST_CHK_RD;
      end
      ST_CHK_END: begin
        if (sts_i.parse_ok) begin
          cmd_o.clr_ptr = 1'b1;
          state_d       = ST_SND_RD;
        end else begin
          cmd_o.clear_fill = 1'b1;
          ovf_d            = 1'b0;
          state_d          = ST_ERR;
        end
      end
      ST_SND_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SND_LD;
      end
      ST_SND_LD: begin
        // hold the read byte until the output word is free
        if (sts_i.out_free) begin
          cmd_o.load_data = 1'b1;
          cmd_o.ptr_inc   = 1'b1;
          if (sts_i.last_byte) begin
            cmd_o.clear_fill = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            state_d = ST_SND_RD;
          end
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== src/command_line_collect_validate_top.sv =====
// Command line collector and checker.
// Slave stream: one received character per word on s_axis_tdata_i.
// Master stream: one result per word; tuser carries the kind (forwarded
// byte, invalid command, line overflow), tdata the forwarded byte (zero for
// errors), tlast marks the final result caused by one input byte.
// Ordinary bytes, CR/LF, erase bytes and a terminator on an empty line leave
// the controller idle; s_axis_tready_o is high whenever the controller is idle.
// A byte that overflows the line loads its error word once the output word is
// free, and input is ready again as that word appears.
// A terminator on a non-empty line walks the line buffer through its single
// read port: each byte is read and then fed to the checker, the result is
// decided, and for a valid line each byte is read again and then loaded into
// the output word; an invalid line yields one error word instead.
// A stalled receiver holds the output word; the forwarding walk waits on it,
// and input stays blocked until all results of the terminator are loaded.
// Reset empties the line and the output word; buffer contents are not
// cleared, since only bytes written since the line began are read.
module command_line_collect_validate_top #(
  parameter int unsigned LINE_BYTES = cclv_pkg::LineBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] result_kind
  output logic       m_axis_tlast_o
);

  cclv_pkg::cmd_t cmd;
  cclv_pkg::sts_t sts;

  cclv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cclv_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/cclv_line_checker.sv =====
module cclv_line_checker #(
  parameter int unsigned LINE_BYTES = cclv_pkg::LineBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0] m_axis_tuser_i,   // [1:0] result_kind
  input  logic       m_axis_tlast_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         data_words_o,
  output int         invalid_words_o,
  output int         overflow_words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_CAP = LINE_BYTES - 1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_word_t;

  logic [7:0]   line_buf [LINE_CAP];
  int unsigned  fill_count;
  result_word_t expected_words [$];
  result_word_t oldest_word;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == cclv_pkg::CharSpace) || ((c >= cclv_pkg::CharTab) && (c <= cclv_pkg::CharCr));
  endfunction

  function automatic logic m_char(input logic [7:0] c);
    return (c == cclv_pkg::CharLowM) || (c == cclv_pkg::CharUpM);
  endfunction

  // Past the checked length every position reads as zero.
  function automatic logic [7:0] char_at(input int unsigned i, input int unsigned n);
    return ((i < n) && (i < LINE_CAP)) ? line_buf[i] : cclv_pkg::CharNul;
  endfunction

  function automatic logic line_matches_form(input int unsigned len);
    int unsigned n;
    int unsigned i;
    int unsigned digits;
    n = 0;
    i = 0;
    digits = 0;
    if ((len == 0) || (len > LINE_CAP)) return 1'b0;
    // a zero byte ends the checked part of the line
    while ((n < len) && (line_buf[n] != cclv_pkg::CharNul)) n++;
    while (blank_char(char_at(i, n))) i++;
    if ((char_at(i, n) == cclv_pkg::CharPlus) || (char_at(i, n) == cclv_pkg::CharMinus)) i++;
    while ((char_at(i, n) >= cclv_pkg::CharZero) && (char_at(i, n) <= cclv_pkg::CharNine)) begin
      i++;
      digits++;
    end
    if (digits == 0) return 1'b0;
    while (blank_char(char_at(i, n))) i++;
    if (!m_char(char_at(i, n)) || !m_char(char_at(i + 1, n))) return 1'b0;
    i += 2;
    while (blank_char(char_at(i, n))) i++;
    if ((char_at(i, n) != cclv_pkg::CharZero) && (char_at(i, n) != cclv_pkg::CharOne)) begin
      return 1'b0;
    end
    i++;
    while (blank_char(char_at(i, n))) i++;
    return i >= n;
  endfunction

  task automatic push_word(input logic [1:0] kind, input logic [7:0] data,
                           input logic last);
    result_word_t w;
    w.kind = kind;
    w.data = data;
    w.last = last;
    expected_words.push_back(w);
    case (kind)
      cclv_pkg::KindData:    data_words_o++;
      cclv_pkg::KindInvalid: invalid_words_o++;
      default:               overflow_words_o++;
    endcase
  endtask

  task automatic predict_line_results(input logic [7:0] c);
    int unsigned i;
    if (c == cclv_pkg::CharTerm) begin
      if (fill_count != 0) begin
        if (line_matches_form(fill_count)) begin
          for (i = 0; i < fill_count; i++) begin
            push_word(cclv_pkg::KindData, line_buf[i], (i + 1) == fill_count);
          end
        end else begin
          push_word(cclv_pkg::KindInvalid, 8'h00, 1'b1);
        end
        fill_count = 0;
      end
    end else if ((c == cclv_pkg::CharCr) || (c == cclv_pkg::CharLf)) begin
      // drop
    end else if ((c == cclv_pkg::CharBs) || (c == cclv_pkg::CharDel)) begin
      if (fill_count > 0) fill_count--;
    end else if (fill_count < LINE_CAP) begin
      line_buf[fill_count] = c;
      fill_count++;
    end else begin
      fill_count = 0;
      push_word(cclv_pkg::KindOverflow, 8'h00, 1'b1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count = 0;
      expected_words.delete();
      pending_o = 0;
    end else begin
      // match outputs first so a stray word cannot pair with a fresh prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_words.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected word kind %0d data %02h last %0d", $realtime,
                     m_axis_tuser_i, m_axis_tdata_i, m_axis_tlast_i);
          end
          mismatch_count_o++;
        end else begin
          oldest_word = expected_words.pop_front();
          if ((oldest_word.kind !== m_axis_tuser_i) || (oldest_word.data !== m_axis_tdata_i)
              || (oldest_word.last !== m_axis_tlast_i)) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: mismatch expected kind %0d data %02h last %0d,",
                       $realtime, oldest_word.kind, oldest_word.data, oldest_word.last);
              $display("    got kind %0d data %02h last %0d",
                       m_axis_tuser_i, m_axis_tdata_i, m_axis_tlast_i);
            end
            mismatch_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_line_results(s_axis_tdata_i);
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== tb/command_line_collect_validate_top_tb.sv =====
module command_line_collect_validate_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 140;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LONG_HOLD    = 400;
  localparam logic [7:0]  CharVt       = 8'h0B;
  localparam logic [7:0]  CharFf       = 8'h0C;
  localparam logic [7:0]  CharLowA     = 8'h61;
  localparam logic [7:0]  CharLowZ     = 8'h7A;
  localparam logic [7:0]  CharMax      = 8'hFF;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  int mismatch_count;
  int pending_words;
  int data_words;
  int invalid_words;
  int overflow_words;

  int          snd_idle_pct;
  int          rcv_idle_pct;
  int unsigned sent_bytes;
  bit          long_stall_req;
  logic [7:0]  line_q [$];

  always #5ns clk = ~clk;

  command_line_collect_validate_top #(
    .LINE_BYTES(cclv_pkg::LineBytes)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  cclv_line_checker #(
    .LINE_BYTES(cclv_pkg::LineBytes)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_words),
    .data_words_o    (data_words),
    .invalid_words_o (invalid_words),
    .overflow_words_o(overflow_words)
  );

  // Offer one word and hold it until taken; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_line();
    foreach (line_q[k]) send_byte(line_q[k]);
    line_q.delete();
  endtask

  // Drop valid so the last word is not offered again, then wait for all results.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0, 1:    return cclv_pkg::CharSpace;
      2:       return cclv_pkg::CharTab;
      3:       return CharVt;
      default: return CharFf;
    endcase
  endfunction

  // Append a byte, sometimes behind dropped CR/LF or a junk byte that gets erased.
  task automatic push_char(input logic [7:0] c);
    if ($urandom_range(0, 99) < 6) begin
      line_q.push_back($urandom_range(0, 1) ? cclv_pkg::CharCr : cclv_pkg::CharLf);
    end
    if ($urandom_range(0, 99) < 5) begin
      line_q.push_back(8'($urandom_range(cclv_pkg::CharTerm + 8'd1,
                                         cclv_pkg::CharDel - 8'd1)));
      line_q.push_back($urandom_range(0, 1) ? cclv_pkg::CharBs : cclv_pkg::CharDel);
    end
    line_q.push_back(c);
  endtask

  task automatic add_blanks(input int unsigned max_blanks);
    repeat ($urandom_range(0, max_blanks)) push_char(pick_blank());
  endtask

  task automatic build_command();
    int unsigned k;
    add_blanks(2);
    case ($urandom_range(0, 2))
      1:       push_char(cclv_pkg::CharPlus);
      2:       push_char(cclv_pkg::CharMinus);
      default: ;
    endcase
    repeat ($urandom_range(1, 4)) begin
      push_char(8'($urandom_range(cclv_pkg::CharZero, cclv_pkg::CharNine)));
    end
    add_blanks(2);
    repeat (2) push_char($urandom_range(0, 1) ? cclv_pkg::CharUpM : cclv_pkg::CharLowM);
    add_blanks(2);
    push_char($urandom_range(0, 1) ? cclv_pkg::CharOne : cclv_pkg::CharZero);
    add_blanks(2);
    // break a few commands with one random byte
    if ($urandom_range(0, 99) < 15) begin
      k = $urandom_range(0, line_q.size() - 1);
      line_q[k] = 8'($urandom_range(0, 255));
    end
    line_q.push_back(cclv_pkg::CharTerm);
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) line_q.push_back(cclv_pkg::CharTerm);
  endtask

  task automatic build_overflow();
    repeat (cclv_pkg::LineBytes - 1 + $urandom_range(1, 3)) begin
      line_q.push_back(8'($urandom_range(CharLowA, CharLowZ)));
    end
    line_q.push_back(cclv_pkg::CharTerm);
  endtask

  // Receiver: random ready, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", quiet_cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned done_bytes;
    int unsigned phase;
    int unsigned pick;
    rst_n          = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    snd_idle_pct   = 21;
    rcv_idle_pct   = 88;
    sent_bytes     = 0;
    long_stall_req = 1'b0;
    phase          = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // terminator and erase on an empty line
    line_q.push_back(cclv_pkg::CharTerm);
    line_q.push_back(cclv_pkg::CharBs);
    line_q.push_back(cclv_pkg::CharDel);
    send_line();
    // erased junk, sign, blanks, mixed-case m, dropped CR/LF
    push_text("x");
    line_q.push_back(cclv_pkg::CharBs);
    push_text("-9 mM\t0 ");
    line_q.push_back(cclv_pkg::CharCr);
    line_q.push_back(cclv_pkg::CharLf);
    line_q.push_back(cclv_pkg::CharTerm);
    send_line();
    // zero byte ends the check, whole line still forwarded
    push_text("1mm0");
    line_q.push_back(cclv_pkg::CharNul);
    line_q.push_back(CharMax);
    line_q.push_back(cclv_pkg::CharTerm);
    send_line();
    push_text("m");
    line_q.push_back(cclv_pkg::CharTerm);
    send_line();
    wait_results_drained();

    rand_start = sent_bytes;
    done_bytes = 0;
    while (done_bytes < RANDOM_BYTES) begin
      if ((phase == 0) && (done_bytes >= RANDOM_BYTES / 3)) begin
        phase = 1;
        wait_results_drained();
        snd_idle_pct = 88;
        rcv_idle_pct = 21;
        build_overflow();
        send_line();
      end else if ((phase == 1) && (done_bytes >= 2 * RANDOM_BYTES / 3)) begin
        phase = 2;
        wait_results_drained();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        long_stall_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) build_command();
      else if (pick < 94) build_noise();
      else build_overflow();
      send_line();
      done_bytes = sent_bytes - rand_start;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes under three idle mixes and one long output hold-off;",
             sent_bytes);
    $display("checked %0d forwarded bytes, %0d invalid lines, %0d overflows.",
             data_words, invalid_words, overflow_words);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
